FILE: rtl/spd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types, register codes and helpers of the SYN port scan detector.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PORT_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_NS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_BLOCK     = 2'd2;

  localparam logic [15:0] THRESHOLD_RST = 16'd20;
  localparam logic [47:0] WINDOW_RST    = 48'd1000000000;

  localparam logic [7:0] TCP_PROTO_NUM = 8'd6;
  localparam logic [5:0] HOST_LEN      = 6'd32;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  typedef struct packed {
    logic        mode;
    logic [31:0] src_addr;
    logic [5:0]  prefix_len;
    logic [7:0]  protocol;
    logic [15:0] dest_port;
    logic        syn_flag;
    logic [63:0] timestamp_ns;
  } in_word_t;

  typedef struct packed {
    logic        verdict;
    logic        alert;
    logic [31:0] alert_addr;
    logic [63:0] proto_total;
    logic        status;
  } out_word_t;

  // one blocklist entry
  typedef struct packed {
    logic [31:0] addr;
    logic [5:0]  len;
  } blk_ent_t;

  // len is at most 32 here
  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [31:0] m;
    m = '0;
    if (len != 6'd0) begin
      m = 32'hFFFF_FFFF << (HOST_LEN - len);
    end
    return m;
  endfunction

endpackage

FILE: rtl/spd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spd_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/syn_port_scan_detector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// syn_port_scan_detector_core
// SYN port scan detector with a prefix blocklist, built around sweeps of
// on-chip RAMs driven by a single sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken on in_data when start is high and busy is low. Mode 1
//   inserts a blocklist prefix, mode 0 is a parsed packet header.
//   Exactly one result word appears on out_data with out_valid high for one
//   cycle; the receiver cannot stall, so it must take it then.
//   Steps per word, with B stored prefixes and T live trackers:
//     blocklist sweep    over B entries (stops early on a hit)
//     tracker probe      over up to T entries, LRU age sweep over T, update
//     port ring sweep    over up to PORTS_PER_SOURCE slots
//     protocol counter   read, then write
//   All sweeps read one RAM entry per cycle through a registered read port,
//   so the word rate is set by those sweeps; busy stays high until done.
//   Config writes (cfg_we) land at once and are meant for idle periods.
//   Reset clears the fill counts and the protocol counter valid bits; no
//   clearing pass runs, the block is ready the cycle after reset.
//   Blocklist and tracker fill from slot 0 upward and never shrink, so a
//   fill count stands in for per-entry valid bits. The port ring keeps a
//   wrap flag: slots past the fill point read as zero until it wraps.
// ----------------------------------------------------------------------------
module syn_port_scan_detector_core
  import spd_pkg::*;
#(
  parameter int BLOCK_ENTRIES    = 1024,
  parameter int TRACK_ENTRIES    = 1024,
  parameter int PORTS_PER_SOURCE = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              in_data,
  output logic                  out_valid,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int BAW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
  localparam int BCW = $clog2(BLOCK_ENTRIES + 1);
  localparam int TAW = (TRACK_ENTRIES > 1) ? $clog2(TRACK_ENTRIES) : 1;
  localparam int TCW = $clog2(TRACK_ENTRIES + 1);
  localparam int PSW = $clog2(PORTS_PER_SOURCE);
  localparam int PCW = $clog2(PORTS_PER_SOURCE + 1);
  localparam int PAW = $clog2(TRACK_ENTRIES * PORTS_PER_SOURCE);
  localparam int SC1 = (BCW > TCW) ? BCW : TCW;
  localparam int SCW = (SC1 > PCW) ? SC1 : PCW;

  typedef struct packed {
    logic [31:0]    key;
    logic [63:0]    start_ts;
    logic [15:0]    cnt;
    logic           alerted;
    logic [PSW-1:0] next;
    logic           wrapped;
    logic [TAW-1:0] age;
  } trk_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_BSCAN = 8'b0000_0010,
    ST_TSCAN = 8'b0000_0100,
    ST_TAGE  = 8'b0000_1000,
    ST_TUPD  = 8'b0001_0000,
    ST_PSCAN = 8'b0010_0000,
    ST_CREAD = 8'b0100_0000,
    ST_CWR   = 8'b1000_0000
  } state_t;

  // config registers
  logic [15:0] thr_r;
  logic [47:0] win_r;
  logic        ab_r;

  state_t         state_r, state_nxt;
  in_word_t       item_r, item_nxt;
  logic [SCW-1:0] scan_idx_r, scan_idx_nxt;
  logic [SCW-1:0] pend_idx_r, pend_idx_nxt;
  logic           pend_r, pend_nxt;
  logic [BCW-1:0] bcnt_r, bcnt_nxt;
  logic [TCW-1:0] tcnt_r, tcnt_nxt;
  logic [TAW-1:0] e_r, e_nxt;
  logic [TAW-1:0] best_idx_r, best_idx_nxt;
  logic [TAW-1:0] best_age_r, best_age_nxt;
  logic [TCW-1:0] old_age_r, old_age_nxt;
  logic           new_r, new_nxt;
  trk_t           ent_r, ent_nxt;
  logic [PAW-1:0] pbase_r, pbase_nxt;
  out_word_t      res_r, res_nxt;
  out_word_t      out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [255:0]   pv_r, pv_nxt;

  // RAM ports
  logic           b_we;
  logic [BAW-1:0] b_waddr, b_raddr;
  blk_ent_t       b_wdata, b_rdata;
  logic           t_we;
  logic [TAW-1:0] t_waddr, t_raddr;
  trk_t           t_wdata, t_rdata;
  logic           p_we;
  logic [PAW-1:0] p_waddr, p_raddr;
  logic [15:0]    p_wdata, p_rdata;
  logic           c_we;
  logic [63:0]    c_wdata, c_rdata;

  logic [SCW-1:0] lim;
  logic           issue, scan_done, fin, hit_b;
  logic [5:0]     ins_len;
  logic [31:0]    ins_addr;
  logic [63:0]    diff, cval, csum;
  logic [15:0]    pval, ncnt;
  logic [PSW-1:0] nn;
  trk_t           rw, uw;

  spd_ram #(.DEPTH(BLOCK_ENTRIES), .WIDTH($bits(blk_ent_t))) u_blk_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  spd_ram #(.DEPTH(TRACK_ENTRIES), .WIDTH($bits(trk_t))) u_trk_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  spd_ram #(.DEPTH(TRACK_ENTRIES * PORTS_PER_SOURCE), .WIDTH(16)) u_port_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  spd_ram #(.DEPTH(256), .WIDTH(64)) u_cnt_ram (
    .clk(clk), .we(c_we), .waddr(item_r.protocol), .wdata(c_wdata),
    .raddr(item_r.protocol), .rdata(c_rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // prefix insert: clamp length, keep only the prefix bits
  assign ins_len  = (item_r.prefix_len > HOST_LEN) ? HOST_LEN : item_r.prefix_len;
  assign ins_addr = item_r.src_addr & prefix_mask(ins_len);

  always_comb begin
    if (state_r == ST_BSCAN) begin
      lim = SCW'(bcnt_r);
    end else if (state_r == ST_TSCAN || state_r == ST_TAGE) begin
      lim = SCW'(tcnt_r);
    end else begin
      lim = SCW'(PORTS_PER_SOURCE);
    end
  end

  assign issue     = (scan_idx_r < lim);
  assign scan_done = !issue && !pend_r;

  assign hit_b = item_r.mode
               ? (b_rdata.len == ins_len && b_rdata.addr == ins_addr)
               : (((item_r.src_addr ^ b_rdata.addr) & prefix_mask(b_rdata.len)) == 32'd0);

  assign diff = item_r.timestamp_ns - ent_r.start_ts;
  assign pval = (ent_r.wrapped || pend_idx_r < SCW'(ent_r.next)) ? p_rdata : 16'd0;
  assign ncnt = (ent_r.cnt < COUNT_MAX) ? ent_r.cnt + 16'd1 : ent_r.cnt;
  assign nn   = (ent_r.next == PSW'(PORTS_PER_SOURCE - 1)) ? '0 : ent_r.next + PSW'(1);
  assign cval = pv_r[item_r.protocol] ? c_rdata : 64'd0;
  assign csum = cval + 64'd1;

  always_comb begin
    rw          = '0;
    rw.key      = item_r.src_addr;
    rw.start_ts = item_r.timestamp_ns;
    rw.cnt      = 16'd1;
    rw.next     = PSW'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    scan_idx_nxt  = scan_idx_r;
    pend_idx_nxt  = pend_idx_r;
    pend_nxt      = 1'b0;
    bcnt_nxt      = bcnt_r;
    tcnt_nxt      = tcnt_r;
    e_nxt         = e_r;
    best_idx_nxt  = best_idx_r;
    best_age_nxt  = best_age_r;
    old_age_nxt   = old_age_r;
    new_nxt       = new_r;
    ent_nxt       = ent_r;
    pbase_nxt     = pbase_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    pv_nxt        = pv_r;
    fin           = 1'b0;
    uw            = ent_r;
    uw.age        = '0;

    b_we    = 1'b0;
    b_waddr = bcnt_r[BAW-1:0];
    b_wdata = '{addr: ins_addr, len: ins_len};
    b_raddr = scan_idx_r[BAW-1:0];
    t_we    = 1'b0;
    t_waddr = e_r;
    t_wdata = rw;
    t_raddr = scan_idx_r[TAW-1:0];
    p_we    = 1'b0;
    p_waddr = pbase_r;
    p_wdata = item_r.dest_port;
    p_raddr = pbase_r + PAW'(scan_idx_r);
    c_we    = 1'b0;
    c_wdata = csum;

    // common sweep stepping
    if (issue) begin
      scan_idx_nxt = scan_idx_r + SCW'(1);
    end
    pend_nxt     = issue && state_r != ST_IDLE;
    pend_idx_nxt = scan_idx_r;

    unique case (state_r)
      ST_IDLE: begin
        scan_idx_nxt = '0;
        pend_nxt     = 1'b0;
        if (start) begin
          item_nxt  = in_data;
          res_nxt   = '0;
          state_nxt = ST_BSCAN;
        end
      end

      ST_BSCAN: begin
        if (pend_r && hit_b) begin
          res_nxt.verdict = !item_r.mode;
          fin             = 1'b1;
        end else if (scan_done) begin
          scan_idx_nxt = '0;
          if (item_r.mode) begin
            if (bcnt_r < BCW'(BLOCK_ENTRIES)) begin
              b_we     = 1'b1;
              bcnt_nxt = bcnt_r + BCW'(1);
            end else begin
              res_nxt.status = 1'b1;
            end
            fin = 1'b1;
          end else if (item_r.protocol == TCP_PROTO_NUM && item_r.syn_flag) begin
            best_idx_nxt = '0;
            best_age_nxt = '0;
            state_nxt    = ST_TSCAN;
          end else begin
            state_nxt = ST_CREAD;
          end
        end
      end

      ST_TSCAN: begin
        if (pend_r && t_rdata.age > best_age_r) begin
          best_age_nxt = t_rdata.age;
          best_idx_nxt = pend_idx_r[TAW-1:0];
        end
        if (pend_r && t_rdata.key == item_r.src_addr) begin
          e_nxt        = pend_idx_r[TAW-1:0];
          ent_nxt      = t_rdata;
          old_age_nxt  = TCW'(t_rdata.age);
          new_nxt      = 1'b0;
          scan_idx_nxt = '0;
          pend_nxt     = 1'b0;
          state_nxt    = ST_TAGE;
        end else if (scan_done) begin
          new_nxt = 1'b1;
          if (tcnt_r < TCW'(TRACK_ENTRIES)) begin
            e_nxt       = tcnt_r[TAW-1:0];
            old_age_nxt = tcnt_r;
          end else begin
            // full: the oldest rank is replaced
            e_nxt       = best_idx_r;
            old_age_nxt = TCW'(best_age_r);
          end
          scan_idx_nxt = '0;
          state_nxt    = ST_TAGE;
        end
      end

      ST_TAGE: begin
        pbase_nxt = PAW'(e_r) * PAW'(PORTS_PER_SOURCE);
        if (pend_r && pend_idx_r[TAW-1:0] != e_r && TCW'(t_rdata.age) < old_age_r) begin
          t_we        = 1'b1;
          t_waddr     = pend_idx_r[TAW-1:0];
          t_wdata     = t_rdata;
          t_wdata.age = t_rdata.age + TAW'(1);
        end
        if (scan_done) begin
          scan_idx_nxt = '0;
          state_nxt    = ST_TUPD;
        end
      end

      ST_TUPD: begin
        scan_idx_nxt = '0;
        pend_nxt     = 1'b0;
        if (new_r || diff >= {16'd0, win_r}) begin
          // new entry or window restart
          t_we = 1'b1;
          p_we = 1'b1;
          if (new_r && tcnt_r < TCW'(TRACK_ENTRIES)) begin
            tcnt_nxt = tcnt_r + TCW'(1);
          end
          state_nxt = ST_CREAD;
        end else begin
          state_nxt = ST_PSCAN;
        end
      end

      ST_PSCAN: begin
        t_wdata = uw;
        if (pend_r && pval == item_r.dest_port) begin
          t_we         = 1'b1;
          scan_idx_nxt = '0;
          pend_nxt     = 1'b0;
          state_nxt    = ST_CREAD;
        end else if (scan_done) begin
          p_we          = 1'b1;
          p_waddr       = pbase_r + PAW'(ent_r.next);
          t_we          = 1'b1;
          t_wdata.next  = nn;
          t_wdata.wrapped = ent_r.wrapped | (nn == '0);
          t_wdata.cnt   = ncnt;
          scan_idx_nxt  = '0;
          state_nxt     = ST_CREAD;
          if (ncnt > thr_r && !ent_r.alerted) begin
            t_wdata.alerted    = 1'b1;
            res_nxt.alert      = 1'b1;
            res_nxt.alert_addr = item_r.src_addr;
            if (ab_r) begin
              // no entry covers this source, so no duplicate check is needed
              if (bcnt_r < BCW'(BLOCK_ENTRIES)) begin
                b_we     = 1'b1;
                b_wdata  = '{addr: item_r.src_addr, len: HOST_LEN};
                bcnt_nxt = bcnt_r + BCW'(1);
              end
              res_nxt.verdict = 1'b1;
              fin             = 1'b1;
            end
          end
        end
      end

      ST_CREAD: begin
        pend_nxt  = 1'b0;
        state_nxt = ST_CWR;
      end

      ST_CWR: begin
        pend_nxt                 = 1'b0;
        c_we                     = 1'b1;
        pv_nxt[item_r.protocol]  = 1'b1;
        res_nxt.proto_total      = csum;
        fin                      = 1'b1;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      out_nxt       = res_nxt;
      out_valid_nxt = 1'b1;
      pend_nxt      = 1'b0;
      scan_idx_nxt  = '0;
      state_nxt     = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      scan_idx_r  <= '0;
      bcnt_r      <= '0;
      tcnt_r      <= '0;
      out_valid_r <= 1'b0;
      pv_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      scan_idx_r  <= scan_idx_nxt;
      bcnt_r      <= bcnt_nxt;
      tcnt_r      <= tcnt_nxt;
      out_valid_r <= out_valid_nxt;
      pv_r        <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    pend_idx_r <= pend_idx_nxt;
    e_r        <= e_nxt;
    best_idx_r <= best_idx_nxt;
    best_age_r <= best_age_nxt;
    old_age_r  <= old_age_nxt;
    new_r      <= new_nxt;
    ent_r      <= ent_nxt;
    pbase_r    <= pbase_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RST;
      win_r <= WINDOW_RST;
      ab_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PORT_THRESHOLD: thr_r <= cfg_data[15:0];
        CFG_WINDOW_NS:      win_r <= cfg_data;
        CFG_AUTO_BLOCK:     ab_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // ---- assertions ----
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while sequencer busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not start work");

  a_blk_fill: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r <= BCW'(BLOCK_ENTRIES))
    else $error("blocklist fill count overflow");

  a_trk_fill: assert property (@(posedge clk) disable iff (!rst_n)
    tcnt_r <= TCW'(TRACK_ENTRIES))
    else $error("tracker fill count overflow");

  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for syn_port_scan_detector_core: blocklist inserts,
// prefix drops, SYN scan tracking with alerts and auto-block, and the
// per-protocol counters. Every word is checked against a local predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import spd_pkg::*;

  localparam int BLK_N  = 1024;
  localparam int TRK_N  = 1024;
  localparam int RING_N = 64;

  // Scoreboard: holds a private copy of the detector state, works out the
  // result of every accepted word and checks the strobed results in order.
  class scan_scoreboard;
    logic [15:0] thresh;
    logic [47:0] window;
    logic        autob;

    logic [31:0] blk_addr [BLK_N];
    logic [5:0]  blk_len  [BLK_N];
    bit          blk_v    [BLK_N];

    logic [31:0] trk_key  [TRK_N];
    bit          trk_v    [TRK_N];
    logic [63:0] trk_t0   [TRK_N];
    logic [15:0] trk_cnt  [TRK_N];
    bit          trk_alrt [TRK_N];
    int          trk_next [TRK_N];
    int          trk_age  [TRK_N];
    logic [15:0] ring     [TRK_N][RING_N];

    logic [63:0] proto_cnt [256];

    out_word_t due_words[$];
    int errors, packets, inserts, alerts, drops;

    function new();
      thresh = THRESHOLD_RST;
      window = WINDOW_RST;
      autob  = 1'b0;
      foreach (blk_v[i]) blk_v[i] = 1'b0;
      foreach (trk_v[i]) trk_v[i] = 1'b0;
      foreach (proto_cnt[i]) proto_cnt[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PORT_THRESHOLD: thresh = val[15:0];
        CFG_WINDOW_NS:      window = val;
        CFG_AUTO_BLOCK:     autob  = val[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] mask_of(logic [5:0] len);
      return (len == 6'd0) ? 32'h0 : (32'hFFFF_FFFF << (6'd32 - len));
    endfunction

    function bit covered(logic [31:0] a);
      foreach (blk_v[i])
        if (blk_v[i] && ((a ^ blk_addr[i]) & mask_of(blk_len[i])) == 32'h0) return 1'b1;
      return 1'b0;
    endfunction

    // returns 1 when the list is full and the prefix is new
    function bit add_prefix(logic [31:0] a, logic [5:0] len);
      if (len > HOST_LEN) len = HOST_LEN;
      a &= mask_of(len);
      foreach (blk_v[i])
        if (blk_v[i] && blk_len[i] == len && blk_addr[i] == a) return 1'b0;
      foreach (blk_v[i])
        if (!blk_v[i]) begin
          blk_v[i] = 1'b1; blk_addr[i] = a; blk_len[i] = len;
          return 1'b0;
        end
      return 1'b1;
    endfunction

    function void promote(int e, bit had);
      int old;
      old = had ? trk_age[e] : 32'h7FFF_FFFF;
      foreach (trk_v[i])
        if (i != e && trk_v[i] && trk_age[i] < old) trk_age[i]++;
      trk_age[e] = 0;
    endfunction

    function void renew(int e, logic [63:0] now, logic [15:0] port);
      trk_t0[e] = now; trk_cnt[e] = 16'd1; trk_alrt[e] = 1'b0;
      for (int k = 0; k < RING_N; k++) ring[e][k] = 16'h0;
      ring[e][0] = port;
      trk_next[e] = 1 % RING_N;
    endfunction

    function void note_word(in_word_t w);
      out_word_t o;
      int e, idx;
      bit had, seen;
      o = '0; e = -1;
      if (w.mode) begin
        inserts++;
        o.status = add_prefix(w.src_addr, w.prefix_len);
        due_words.push_back(o);
        return;
      end
      packets++;
      if (covered(w.src_addr)) begin
        o.verdict = 1'b1; drops++;
        due_words.push_back(o);
        return;
      end
      if (w.protocol == TCP_PROTO_NUM && w.syn_flag) begin
        foreach (trk_v[i])
          if (e < 0 && trk_v[i] && trk_key[i] == w.src_addr) e = i;
        if (e < 0) begin
          had = 1'b0;
          foreach (trk_v[i]) if (e < 0 && !trk_v[i]) e = i;
          if (e < 0) begin
            // tracker full: evict the oldest rank
            e = 0; had = 1'b1;
            for (int i = 1; i < TRK_N; i++) if (trk_age[i] > trk_age[e]) e = i;
          end
          promote(e, had);
          trk_v[e] = 1'b1; trk_key[e] = w.src_addr;
          renew(e, w.timestamp_ns, w.dest_port);
        end else begin
          promote(e, 1'b1);
          if ((w.timestamp_ns - trk_t0[e]) < {16'h0, window}) begin
            seen = 1'b0;
            for (int k = 0; k < RING_N; k++) if (ring[e][k] == w.dest_port) seen = 1'b1;
            if (!seen) begin
              idx = trk_next[e];
              ring[e][idx] = w.dest_port;
              trk_next[e] = (idx + 1) % RING_N;
              if (trk_cnt[e] < COUNT_MAX) trk_cnt[e]++;
              if (trk_cnt[e] > thresh && !trk_alrt[e]) begin
                trk_alrt[e] = 1'b1; alerts++;
                o.alert = 1'b1; o.alert_addr = w.src_addr;
                if (autob) begin
                  void'(add_prefix(w.src_addr, HOST_LEN));
                  o.verdict = 1'b1; drops++;
                  due_words.push_back(o);
                  return;
                end
              end
            end
          end else begin
            renew(e, w.timestamp_ns, w.dest_port);
          end
        end
      end
      proto_cnt[w.protocol]++;
      o.proto_total = proto_cnt[w.protocol];
      due_words.push_back(o);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    endtask

    task check_word(out_word_t got);
      out_word_t want;
      if (due_words.size() == 0) begin
        report("unexpected word", got.proto_total, 64'd0);
        return;
      end
      want = due_words.pop_front();
      if (got.verdict !== want.verdict)
        report("verdict", 64'(got.verdict), 64'(want.verdict));
      if (got.alert !== want.alert) report("alert", 64'(got.alert), 64'(want.alert));
      if (got.alert_addr !== want.alert_addr)
        report("alert_addr", 64'(got.alert_addr), 64'(want.alert_addr));
      if (got.proto_total !== want.proto_total)
        report("proto_total", got.proto_total, want.proto_total);
      if (got.status !== want.status) report("status", 64'(got.status), 64'(want.status));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_word_t              in_data = '0;
  logic                  out_valid;
  out_word_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  scan_scoreboard sb = new();
  bit          idle_on = 1'b1;
  logic [63:0] cur_ts = '0;
  int          ts_step = 200;
  logic [31:0] pool [8];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  syn_port_scan_detector_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // results cannot be held off: take every strobed word
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_word(out_data);
  end

  // Drive one word; it is taken at the first edge with busy low. start is
  // left high afterwards unless the next call inserts a gap.
  task send(in_word_t w);
    if (idle_on && $urandom_range(99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_word(w);
  endtask

  task pkt(logic [31:0] src, logic [7:0] proto, logic [15:0] port, logic syn);
    in_word_t w;
    w = '0;
    w.src_addr = src; w.protocol = proto; w.dest_port = port; w.syn_flag = syn;
    w.prefix_len = 6'($urandom_range(63));   // ignored for packets
    w.timestamp_ns = cur_ts;
    send(w);
  endtask

  task ins(logic [31:0] a, logic [5:0] len);
    in_word_t w;
    w = '0;
    w.mode = 1'b1; w.src_addr = a; w.prefix_len = len;
    w.protocol = 8'($urandom); w.dest_port = 16'($urandom); w.syn_flag = 1'($urandom);
    w.timestamp_ns = {$urandom, $urandom};
    send(w);
  endtask

  // register writes only once the block has drained
  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    start <= 1'b0;
    wait (sb.due_words.size() == 0);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // one SYN sweep from a pool source: mostly fresh ports, a few repeats
  task scan_burst(int n);
    logic [31:0] src;
    logic [15:0] base;
    src  = pool[$urandom_range(7)];
    base = 16'($urandom);
    for (int k = 0; k < n; k++) begin
      cur_ts += 64'($urandom_range(0, ts_step));
      pkt(src, TCP_PROTO_NUM, ($urandom_range(9) == 0) ? base : base + k[15:0], 1'b1);
    end
  endtask

  task random_phase(int items);
    int done, r, n;
    in_word_t w;
    done = 0;
    foreach (pool[i]) pool[i] = {8'd10, 24'($urandom)};
    while (done < items) begin
      r = $urandom_range(99);
      if (r < 70) begin
        n = $urandom_range(2, 14);
        scan_burst(n);
        done += n;
      end else if (r < 85) begin
        w = {$urandom, $urandom, $urandom, $urandom};
        w.mode = 1'b0;
        send(w);
        done++;
      end else if (r < 93) begin
        // narrow prefixes, so the pool is rarely hit by chance
        ins($urandom, 6'($urandom_range(20, 63)));
        done++;
      end else begin
        cur_ts += 64'($urandom_range(0, ts_step));
        pkt(pool[$urandom_range(7)], ($urandom_range(1)) ? TCP_PROTO_NUM : 8'($urandom),
            16'($urandom), 1'b0);
        done++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words under reset settings
    ins(32'hC0A8_1234, 6'd16);         // low bits dropped on store
    ins(32'hC0A8_0000, 6'd16);         // same prefix again
    ins(32'hAC10_0505, 6'd63);         // length above 32
    ins(32'hFFFF_FFFF, 6'd32);
    pkt(32'hC0A8_4D01, TCP_PROTO_NUM, 16'd80, 1'b1);
    pkt(32'hAC10_0505, 8'd17, 16'd53, 1'b0);
    pkt(32'hAC10_0504, 8'd17, 16'd53, 1'b0);
    pkt(32'hFFFF_FFFF, 8'd0, 16'hFFFF, 1'b1);
    pkt(32'h0A01_0101, 8'd0, 16'hFFFF, 1'b0);
    pkt(32'h0A01_0101, 8'd255, 16'h0000, 1'b1);
    pkt(32'h0000_0000, TCP_PROTO_NUM, 16'd443, 1'b0);
    pkt(32'h0A09_0909, TCP_PROTO_NUM, 16'd0, 1'b1);   // new source, port zero
    pkt(32'h0A09_0909, TCP_PROTO_NUM, 16'd0, 1'b1);
    pkt(32'h0A09_0909, TCP_PROTO_NUM, 16'hFFFF, 1'b1);
    pkt(32'h0A09_0908, TCP_PROTO_NUM, 16'd7, 1'b1);
    pkt(32'h0A09_0908, TCP_PROTO_NUM, 16'd0, 1'b1);   // cleared slot reads as zero
    cur_ts = 64'd2_000_000_000;                       // past the window: restart
    pkt(32'h0A09_0909, TCP_PROTO_NUM, 16'd22, 1'b1);
    pkt(32'h0A09_0909, TCP_PROTO_NUM, 16'd0, 1'b1);

    // tight window, low threshold, auto-block; time wraps through zero
    write_reg(CFG_PORT_THRESHOLD, 48'd3);
    write_reg(CFG_WINDOW_NS, 48'd1500);
    write_reg(CFG_AUTO_BLOCK, 48'd1);
    cur_ts  = 64'hFFFF_FFFF_FFFF_F000;
    ts_step = 300;
    random_phase(200);

    // alert on the first new port of each source, endless window, no idling at all
    write_reg(CFG_PORT_THRESHOLD, 48'd0);
    write_reg(CFG_WINDOW_NS, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_AUTO_BLOCK, 48'd0);
    idle_on = 1'b0;
    ts_step = 100_000;
    random_phase(180);
    idle_on = 1'b1;

    // threshold never reached, zero window restarts every time
    write_reg(CFG_PORT_THRESHOLD, 48'hFFFF);
    write_reg(CFG_WINDOW_NS, 48'd0);
    ts_step = 50;
    random_phase(150);

    // mid settings, then a zero-length prefix that covers everything
    write_reg(CFG_PORT_THRESHOLD, 48'd10);
    write_reg(CFG_WINDOW_NS, 48'h8000_0000_0000);
    write_reg(CFG_AUTO_BLOCK, 48'd1);
    random_phase(100);
    ins($urandom, 6'd0);
    for (int k = 0; k < 8; k++) pkt($urandom, 8'($urandom), 16'($urandom), 1'($urandom));

    start <= 1'b0;
    wait (sb.due_words.size() == 0);
    repeat (300) @(posedge clk);

    $display("covered %0d packets and %0d inserts, %0d alerts, %0d drops",
             sb.packets, sb.inserts, sb.alerts, sb.drops);
    if (sb.due_words.size() != 0)
      sb.report("words never seen", 64'(sb.due_words.size()), 64'd0);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout waiting for the detector");
    $display("status: fail");
    $finish;
  end

endmodule
